@@ hw/rtl/bbp_pkg.sv @@
package bbp_pkg;

    localparam int DATA_W    = 8;
    localparam int ORDER_W   = 64;
    localparam int ENTRY_W   = 4;
    localparam int ENTRY_N   = ORDER_W / ENTRY_W;
    localparam int CMP_W     = ENTRY_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic                DIRECTION_RST = 1'b0;
    localparam logic [ORDER_W-1:0]  ORDER_RST     = 64'hFEDC_BA98_7654_3210;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ORDER = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIX,
        S_EMIT
    } bbp_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic fix;
        logic emit;
    } bbp_cmd_t;

    typedef struct packed {
        logic trigger;
        logic scan_last;
        logic emit_last;
    } bbp_status_t;

endpackage

@@ hw/rtl/bbp_ctrl.sv @@
module bbp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  bbp_pkg::bbp_status_t status,
    output logic                 busy,
    output bbp_pkg::bbp_cmd_t    cmd
);
    import bbp_pkg::*;

    bbp_state_t state_reg;
    bbp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && status.trigger)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = 1'b1;
        cmd  = '0;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_FIX:
            begin
                cmd.fix = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    a_scan_to_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && status.scan_last) |=> (state_reg == S_FIX))
        else $error("scan end did not move to fixup");

    a_fix_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX) |=> (state_reg == S_EMIT))
        else $error("fixup did not move to emission");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.fix, cmd.emit}))
        else $error("more than one datapath command active");

endmodule

@@ hw/rtl/bbp_datapath.sv @@
module bbp_datapath #(
    parameter int BLOCK_LEN = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bbp_pkg::bbp_cmd_t               cmd,
    output bbp_pkg::bbp_status_t            status,
    input  logic [bbp_pkg::DATA_W-1:0]      data_byte,
    input  logic                            final_byte,
    input  logic                            cfg_we,
    input  logic [bbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bbp_pkg::ORDER_W-1:0]     cfg_data,
    output logic                            out_valid,
    output logic [bbp_pkg::DATA_W-1:0]      out_byte,
    output logic                            out_last
);
    import bbp_pkg::*;

    localparam int IDX_W = $clog2(BLOCK_LEN);
    localparam int CNT_W = $clog2(BLOCK_LEN + 1);

    // entry value modulo the block length, for every 4-bit entry
    function automatic logic [ENTRY_N*IDX_W-1:0] mod_table();
        logic [ENTRY_N*IDX_W-1:0] t;
        t = '0;
        for (int v = 0; v < ENTRY_N; v++)
        begin
            t[v*IDX_W +: IDX_W] = IDX_W'(v % BLOCK_LEN);
        end
        return t;
    endfunction

    localparam logic [ENTRY_N*IDX_W-1:0] MOD_TAB = mod_table();

    logic                direction_reg;
    logic                direction_next;
    logic [ORDER_W-1:0]  order_reg;
    logic [ORDER_W-1:0]  order_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [CNT_W-1:0]    len_reg;
    logic [CNT_W-1:0]    len_next;
    logic                fin_reg;
    logic                fin_next;
    logic [IDX_W-1:0]    i_reg;
    logic [IDX_W-1:0]    i_next;
    logic [CNT_W-1:0]    j_reg;
    logic [CNT_W-1:0]    j_next;
    logic [IDX_W-1:0]    k_reg;
    logic [IDX_W-1:0]    k_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [DATA_W-1:0]   out_byte_reg;
    logic                out_last_reg;
    logic                out_last_next;

    logic [DATA_W-1:0]   buffer_reg [BLOCK_LEN];
    logic [IDX_W-1:0]    map_reg    [BLOCK_LEN];

    logic [ENTRY_W-1:0]  entry;
    logic                entry_small;
    logic                full;
    logic                j_lt_len;
    logic                map_clear;
    logic                map_we;
    logic [IDX_W-1:0]    map_addr;
    logic [IDX_W-1:0]    map_wdata;
    logic [IDX_W-1:0]    src;
    logic [IDX_W-1:0]    src_sel;

    assign entry       = order_reg[ENTRY_W*i_reg +: ENTRY_W];
    assign entry_small = CMP_W'(entry) < CMP_W'(len_reg);
    assign full        = (len_reg == CNT_W'(BLOCK_LEN));
    assign j_lt_len    = (j_reg < len_reg);

    assign status.trigger   = final_byte || (fill_reg == CNT_W'(BLOCK_LEN - 1));
    assign status.scan_last = (i_reg == IDX_W'(BLOCK_LEN - 1));
    assign status.emit_last = (CNT_W'(k_reg) + CNT_W'(1) == len_reg);

    // configuration
    always_comb
    begin
        direction_next = direction_reg;
        order_next     = order_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DIRECTION:   direction_next = cfg_data[0];
                REG_BLOCK_ORDER: order_next     = cfg_data;
                default:         order_next     = order_reg;
            endcase
        end
    end

    // counters
    always_comb
    begin
        fill_next = fill_reg;
        len_next  = len_reg;
        fin_next  = fin_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        if (cmd.load)
        begin
            if (status.trigger)
            begin
                fill_next = '0;
                len_next  = fill_reg + CNT_W'(1);
                fin_next  = final_byte;
                i_next    = '0;
                j_next    = '0;
                k_next    = '0;
            end
            else
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        if (cmd.scan)
        begin
            i_next = i_reg + IDX_W'(1);
            if (!full && entry_small && j_lt_len)
            begin
                j_next = j_reg + CNT_W'(1);
            end
        end
        if (cmd.emit)
        begin
            k_next = k_reg + IDX_W'(1);
        end
    end

    // mapping table: out position k reads buffer[map[k]]
    always_comb
    begin
        map_clear = cmd.load && status.trigger;
        map_we    = 1'b0;
        map_addr  = '0;
        map_wdata = '0;
        if (cmd.scan)
        begin
            if (full)
            begin
                if (!direction_reg)
                begin
                    map_we    = 1'b1;
                    map_addr  = i_reg;
                    map_wdata = MOD_TAB[IDX_W*entry +: IDX_W];
                end
                else if (entry_small)
                begin
                    map_we    = 1'b1;
                    map_addr  = entry[IDX_W-1:0];
                    map_wdata = i_reg;
                end
            end
            else if (entry_small && j_lt_len)
            begin
                map_we = 1'b1;
                if (!direction_reg)
                begin
                    map_addr  = j_reg[IDX_W-1:0];
                    map_wdata = entry[IDX_W-1:0];
                end
                else
                begin
                    map_addr  = entry[IDX_W-1:0];
                    map_wdata = j_reg[IDX_W-1:0];
                end
            end
        end
        // missing tail slots are zero, so the last one owns inverse entry zero
        if (cmd.fix && !full && direction_reg && j_lt_len)
        begin
            map_we    = 1'b1;
            map_addr  = '0;
            map_wdata = IDX_W'(len_reg - CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_clear)
        begin
            for (int m = 0; m < BLOCK_LEN; m++)
            begin
                map_reg[m] <= '0;
            end
        end
        else if (map_we)
        begin
            map_reg[map_addr] <= map_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            buffer_reg[fill_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    // emission
    assign src     = map_reg[k_reg];
    assign src_sel = (CNT_W'(src) < len_reg) ? src : '0;

    always_comb
    begin
        out_valid_next = cmd.emit;
        out_last_next  = 1'b0;
        if (cmd.emit)
        begin
            out_last_next = fin_reg && status.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIRECTION_RST;
            order_reg     <= ORDER_RST;
            fill_reg      <= '0;
            len_reg       <= '0;
            fin_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            direction_reg <= direction_next;
            order_reg     <= order_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            fin_reg       <= fin_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    // read the buffer through the output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg <= buffer_reg[src_sel];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CNT_W'(BLOCK_LEN))
        else $error("fill count reached a full block without emission");

    a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (CNT_W'(k_reg) < len_reg))
        else $error("emission past the end of the run");

    a_last_marked_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_last_reg |-> (out_valid_reg && $past(fin_reg)))
        else $error("last marker without a final run");

endmodule

@@ hw/rtl/block_byte_permuter_top.sv @@
// Block byte permuter. Bytes go in one per start pulse and fill a buffer of BLOCK_LEN
// bytes; a full block, or a shorter tail closed by final_byte, leaves reordered by the
// block_order table (direction 1 applies its inverse). A byte that does not close a
// block leaves busy low. A closing byte keeps busy high while the sequencer walks
// block_order one table entry at a time and builds the byte map, runs a fixup step,
// then sends out one result per cycle through the single buffer read port, marked by
// out_valid. Results cannot be held off. Configuration writes are always taken
// (cfg_ready is high) and must only be issued while busy is low and no run is being
// emitted.
module block_byte_permuter_top #(
    parameter int BLOCK_LEN = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [bbp_pkg::DATA_W-1:0]      data_byte,
    input  logic                            final_byte,
    output logic                            out_valid,
    output logic [bbp_pkg::DATA_W-1:0]      out_byte,
    output logic                            out_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bbp_pkg::ORDER_W-1:0]     cfg_data
);
    import bbp_pkg::*;

    bbp_cmd_t    cmd;
    bbp_status_t status;

    assign cfg_ready = 1'b1;

    bbp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    bbp_datapath #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

endmodule

@@ tb/sv/block_byte_permuter_top_tb.sv @@
`timescale 1ns / 100ps

module block_byte_permuter_top_tb;
    import bbp_pkg::*;

    localparam int BLK          = 16;
    localparam int RUN_CYCLES   = BLK + 1 + BLK;   // table walk, fixup, emit
    localparam int SETTLE       = RUN_CYCLES + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 18;

    localparam logic DIR_SCRAMBLE = 1'b0;
    localparam logic DIR_RESTORE  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] b;
        logic              fin;
    } msg_byte_t;

    typedef struct packed {
        logic [DATA_W-1:0] b;
        logic              last;
    } perm_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [DATA_W-1:0]     data_byte = '0;
    logic                  final_byte = 1'b0;
    logic                  out_valid;
    logic [DATA_W-1:0]     out_byte;
    logic                  out_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_DIRECTION;
    logic [ORDER_W-1:0]    cfg_data = '0;

    // predictor state
    logic                  dir_reg = DIRECTION_RST;
    logic [ORDER_W-1:0]    order_reg = ORDER_RST;
    logic [DATA_W-1:0]     held [BLK];
    int                    fill_cnt = 0;

    msg_byte_t             pending_q [$];
    perm_byte_t            perm_q [$];

    int unsigned           issued_cnt = 0;
    int unsigned           taken_cnt = 0;
    int                    gap_left = 0;
    logic                  burst_mode = 1'b0;
    int unsigned           cycle_cnt = 0;
    int unsigned           mismatch_cnt = 0;
    int unsigned           result_cnt = 0;
    int unsigned           msg_end_cnt = 0;
    int unsigned           reg_write_cnt = 0;

    block_byte_permuter_top #(.BLOCK_LEN(BLK)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Collect one byte; on a full block or a closing byte, queue the reordered run.
    task automatic permute_transfer(input logic [DATA_W-1:0] b, input logic fin);
        logic [3:0] sub [BLK];
        logic [3:0] map [BLK];
        logic [3:0] e;
        int         len;
        int         j;
        int         src;
        if (fill_cnt >= BLK)
            fill_cnt = 0;
        held[fill_cnt] = b;
        fill_cnt++;
        len = fill_cnt;
        if (len < BLK && !fin)
            return;
        for (int i = 0; i < BLK; i++)
        begin
            sub[i] = '0;
            map[i] = '0;
        end
        j = 0;
        for (int i = 0; i < BLK; i++)
        begin
            e = order_reg[4*i +: 4];
            if (len >= BLK)
                sub[i] = e;
            else if (j < len && e < len)
            begin
                sub[j] = e;
                j++;
            end
        end
        if (dir_reg == DIR_SCRAMBLE)
            map = sub;
        else
        begin
            // later table entries win where the table is not a permutation
            for (int i = 0; i < BLK; i++)
            begin
                if (len >= BLK)
                    map[order_reg[4*i +: 4]] = 4'(i);
                else if (i < len)
                    map[sub[i]] = 4'(i);
            end
        end
        for (int k = 0; k < len; k++)
        begin
            src = map[k];
            if (src >= len)
                src = 0;
            perm_q.push_back('{b: held[src], last: fin && (k == len - 1)});
        end
        fill_cnt = 0;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ORDER_W-1:0] rand_perm();
        logic [3:0]         p [BLK];
        logic [3:0]         t;
        logic [ORDER_W-1:0] v;
        int                 j;
        for (int i = 0; i < BLK; i++)
            p[i] = 4'(i);
        for (int i = BLK - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = p[i];
            p[i] = p[j];
            p[j] = t;
        end
        for (int i = 0; i < BLK; i++)
            v[4*i +: 4] = p[i];
        return v;
    endfunction

    // driver: hold start until the transfer, then advance or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && taken_cnt != issued_cnt)
            ;
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_q.size() > 0)
        begin
            data_byte  <= pending_q[0].b;
            final_byte <= pending_q[0].fin;
            void'(pending_q.pop_front());
            start      <= 1'b1;
            issued_cnt <= issued_cnt + 1;
            gap_left   <= pick_gap();
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            permute_transfer(data_byte, final_byte);
            taken_cnt <= taken_cnt + 1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid)
        begin
            result_cnt++;
            if (out_last)
                msg_end_cnt++;
            if (perm_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("cycle %0d: unexpected byte %02h last %0b",
                             cycle_cnt, out_byte, out_last);
            end
            else
            begin
                if (out_byte !== perm_q[0].b || out_last !== perm_q[0].last)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("cycle %0d: expected byte %02h last %0b, got byte %02h last %0b",
                                 cycle_cnt, perm_q[0].b, perm_q[0].last, out_byte, out_last);
                end
                void'(perm_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_cnt, perm_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ORDER_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_DIRECTION)
            dir_reg = val[0];
        else
            order_reg = val;
        reg_write_cnt++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_byte(input logic [DATA_W-1:0] b, input logic fin);
        pending_q.push_back('{b: b, fin: fin});
    endtask

    // wait for every transfer and every result, then let a full run time pass
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || issued_cnt != taken_cnt || start
               || perm_q.size() != 0 || busy);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        int n;
        int len;
        int r;
        logic [ORDER_W-1:0] ord;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset table is the identity: single byte and two byte tails
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hA5, 1'b1);
        wait_idle();

        // reversed table on a full block closed by the final byte
        write_reg(REG_DIRECTION, {{(ORDER_W-1){1'b0}}, DIR_SCRAMBLE});
        write_reg(REG_BLOCK_ORDER, 64'h0123_4567_89AB_CDEF);
        for (int i = 0; i < BLK; i++)
            add_byte(8'(i * 17), i == BLK - 1);
        wait_idle();

        // no entries small enough for a short tail: missing slots read byte 0
        write_reg(REG_BLOCK_ORDER, '1);
        add_byte(8'h3C, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'h5A, 1'b1);
        wait_idle();

        // restore with a table that is not a permutation
        write_reg(REG_DIRECTION, {{(ORDER_W-1){1'b0}}, DIR_RESTORE});
        write_reg(REG_BLOCK_ORDER, '0);
        add_byte(8'h81, 1'b0);
        add_byte(8'h7E, 1'b1);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                ord = rand_perm();
            else if (r < 85)
                ord = {$urandom, $urandom};
            else
            begin
                ord = rand_perm();
                for (int d = 0; d < 3; d++)
                    ord[4*$urandom_range(0, BLK-1) +: 4] = 4'($urandom_range(0, BLK-1));
            end
            write_reg(REG_DIRECTION, ORDER_W'($urandom_range(0, 1)));
            write_reg(REG_BLOCK_ORDER, ord);
            burst_mode = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    len = BLK;
                else if (r < 25)
                    len = 2 * BLK;
                else
                    len = $urandom_range(1, 40);
                // most messages close with a final byte, some run on into the next
                r = $urandom_range(0, 99);
                for (int i = 0; i < len; i++)
                    add_byte(8'($urandom), (i == len - 1) && (r < 85));
                n += len;
            end
            wait_idle();
        end

        $display("Covered %0d byte transfers and %0d reordered bytes out (%0d message ends),",
                 taken_cnt, result_cnt, msg_end_cnt);
        $display("under %0d register writes across both directions and assorted tables.",
                 reg_write_cnt);
        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
        begin
            $display("%0d mismatches", mismatch_cnt);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
